// ===== sv/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared codes and types for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int ActW    = 2;
  localparam int KeyW    = 16;
  localparam int PayW    = 16;
  localparam int StatW   = 2;
  localparam int FillW   = 5;

  localparam logic [ActW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActW-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActW-1:0] ACT_PEEK   = 2'd2;
  localparam logic [ActW-1:0] ACT_NOP    = 2'd3;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic             capture;
    logic             show_head;
    logic [StatW-1:0] status;
  } ssq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } ssq_stat_t;

endpackage

// ===== sv/ssq_if.sv =====
// ----------------------------------------------------------------------------
// ssq_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ssq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] priority_req;
  logic [15:0] payload;

  modport source (output valid, output action, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input action, input priority_req, input payload,
                  output ready);
endinterface

interface ssq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_payload;
  logic [15:0] out_priority;
  logic [4:0]  fill_count;

  modport source (output valid, output status, output out_payload, output out_priority,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input out_payload, input out_priority,
                  input fill_count, output ready);
endinterface

// ===== sv/ssq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssq_ctrl
// Handshake state machine and action decode for the priority queue.
// ----------------------------------------------------------------------------
module ssq_ctrl
  import ssq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ActW-1:0]     action,
  output logic                out_valid,
  input  logic                out_ready,
  input  ssq_stat_t           stat,
  output ssq_cmd_t            cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // a pending result that is being taken frees the output register this cycle
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_nxt = S_HOLD;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.status    = ST_OK;
    unique case (action)
      ACT_INSERT: begin
        if (stat.full) cmd.status = ST_FULL;
        else cmd.insert = accept;
      end
      ACT_REMOVE: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.remove    = accept;
          cmd.show_head = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (stat.empty) cmd.status = ST_EMPTY;
        else cmd.show_head = 1'b1;
      end
      ACT_NOP: begin
        cmd.status = ST_OK;
      end
      default: cmd.status = ST_OK;
    endcase
  end

endmodule

// ===== sv/ssq_dp.sv =====
// ----------------------------------------------------------------------------
// ssq_dp
// Compare-and-shift register array holding the sorted entries, plus the
// result register.
// ----------------------------------------------------------------------------
module ssq_dp
  import ssq_pkg::*;
#(
  parameter int DEPTH = 16
)(
  input  logic              clk,
  input  logic              rst_n,
  input  ssq_cmd_t          cmd,
  output ssq_stat_t         stat,
  input  logic [KeyW-1:0]   in_pri,
  input  logic [PayW-1:0]   in_pay,
  output logic [StatW-1:0]  res_status,
  output logic [PayW-1:0]   res_payload,
  output logic [KeyW-1:0]   res_priority,
  output logic [FillW-1:0]  res_fill
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [KeyW-1:0] pri_r   [DEPTH];
  logic [PayW-1:0] pay_r   [DEPTH];
  logic [KeyW-1:0] pri_nxt [DEPTH];
  logic [PayW-1:0] pay_nxt [DEPTH];
  logic [DEPTH-1:0] le;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW+FillW-1:0] count_ext;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

  // cell keeps its entry when it holds a key not above the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < count_r) && (pri_r[i] <= in_pri);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      pri_nxt[g] = pri_r[g];
      pay_nxt[g] = pay_r[g];
      if (cmd.insert && !le[g]) begin
        if (g == 0) begin
          pri_nxt[g] = in_pri;
          pay_nxt[g] = in_pay;
        end else if (le[(g == 0) ? 0 : g-1]) begin
          pri_nxt[g] = in_pri;
          pay_nxt[g] = in_pay;
        end else begin
          pri_nxt[g] = pri_r[(g == 0) ? 0 : g-1];
          pay_nxt[g] = pay_r[(g == 0) ? 0 : g-1];
        end
      end else if (cmd.remove && (g < DEPTH-1)) begin
        // advance toward the head
        pri_nxt[g] = pri_r[(g < DEPTH-1) ? g+1 : g];
        pay_nxt[g] = pay_r[(g < DEPTH-1) ? g+1 : g];
      end
    end

    always_ff @(posedge clk) begin
      pri_r[g] <= pri_nxt[g];
      pay_r[g] <= pay_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) count_nxt = count_r + CW'(1);
    else if (cmd.remove) count_nxt = count_r - CW'(1);
  end

  assign count_ext = {{FillW{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status   <= cmd.status;
      res_payload  <= cmd.show_head ? pay_r[0] : '0;
      res_priority <= cmd.show_head ? pri_r[0] : '0;
      res_fill     <= count_ext[FillW-1:0];
    end
  end

endmodule

// ===== sv/stable_sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Bounded priority queue, ascending keys, equal keys leave in arrival order.
// ----------------------------------------------------------------------------
// Request items arrive on in_ch: action (insert, remove head, peek head, no-op),
// priority_req and payload. Every request gives exactly one result item on
// out_ch: status (ok, empty, full), head payload and priority for a
// successful remove or peek (zero otherwise), and the entry count after the
// action, kept to its low five bits.
// Entries sit in a compare-and-shift register array: every cell compares its
// key with the new one and keeps, takes the new entry or takes its neighbor's
// in the cycle the request is accepted; its result is in the output register
// the next cycle.
// Throughput is one item per cycle while out_ch is ready; a new request is
// taken in the same cycle the pending result leaves.
// While the receiver stalls, the result is held and in_ch.ready stays low.
// Synchronous reset empties the queue; stored entries are not cleared.
// A full queue drops an insert and reports full.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top
  import ssq_pkg::*;
#(
  parameter int DEPTH = 16
)(
  input  logic      clk,
  input  logic      rst_n,
  ssq_in_if.sink    in_ch,
  ssq_out_if.source out_ch
);

  ssq_cmd_t  cmd;
  ssq_stat_t stat;

  ssq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .action    (in_ch.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_pri       (in_ch.priority_req),
    .in_pay       (in_ch.payload),
    .res_status   (out_ch.status),
    .res_payload  (out_ch.out_payload),
    .res_priority (out_ch.out_priority),
    .res_fill     (out_ch.fill_count)
  );

endmodule
